FILE: hdl/m4m_pkg.sv
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
// Used by m4m_ctrl, m4m_dp and matrix4x4_multiply.
`timescale 1ns / 1ps

package m4m_pkg;

  localparam int ELEM_W    = 32;             // Q16.16 element
  localparam int FRAC_BITS = 16;             // fraction bits dropped after the sum
  localparam int PROD_W    = 2 * ELEM_W;     // one signed product
  localparam int ACC_W     = PROD_W + 2;     // sum of four products, no overflow
  localparam int ADDR_W    = 4;              // 16 entries per matrix
  localparam int STEP_W    = 6;              // 16 elements x 4 terms

  // Controller -> datapath commands
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              issue;      // one multiply-accumulate term enters
    logic [ADDR_W-1:0] left_addr;
    logic [ADDR_W-1:0] right_addr;
    logic              first_term;
    logic              last_term;
    logic              last_elem;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic adv;                     // pipeline moves this cycle
  } stat_t;

endpackage

FILE: hdl/m4m_ctrl.sv
// Sequencer for the 4x4 matrix multiplier: load phase and term issue phase.
// Depends on m4m_pkg; drives the datapath through cmd_t, sees stat_t.
`timescale 1ns / 1ps

module m4m_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output m4m_pkg::cmd_t   cmd,
  input  m4m_pkg::stat_t  stat
);
  import m4m_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_ISSUE = 2'b10
  } state_t;

  state_t              state;
  logic [ADDR_W-1:0]   load_count;
  logic [STEP_W-1:0]   step;

  localparam logic [ADDR_W-1:0] LAST_SLOT = '1;
  localparam logic [STEP_W-1:0] LAST_STEP = '1;

  logic [1:0] row, col, term;

  assign row  = step[5:4];
  assign col  = step[3:2];
  assign term = step[1:0];

  assign in_ready = (state == ST_LOAD);

  always_comb begin
    cmd.wr_en      = in_valid && in_ready;
    cmd.wr_addr    = load_count;
    cmd.issue      = (state == ST_ISSUE);
    cmd.left_addr  = {row, term};
    cmd.right_addr = {term, col};
    cmd.first_term = (term == 2'd0);
    cmd.last_term  = (term == 2'd3);
    cmd.last_elem  = (step == LAST_STEP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      step       <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_valid) begin
            load_count <= load_count + 1'b1;
            if (load_count == LAST_SLOT) begin
              state <= ST_ISSUE;
              step  <= '0;
            end
          end
        end
        ST_ISSUE: begin
          // memories are read at issue, so loading resumes right after the last term
          if (stat.adv) begin
            step <= step + 1'b1;
            if (step == LAST_STEP) state <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

FILE: hdl/m4m_dp.sv
// Datapath of the 4x4 matrix multiplier: element stores, one shared MAC,
// truncating scale, saturation and the output register. Depends on m4m_pkg.
`timescale 1ns / 1ps

module m4m_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [m4m_pkg::ELEM_W-1:0]  left_element,
  input  logic [m4m_pkg::ELEM_W-1:0]  right_element,
  input  m4m_pkg::cmd_t               cmd,
  output m4m_pkg::stat_t              stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [m4m_pkg::ELEM_W-1:0]  product_element,
  output logic                        last_out
);
  import m4m_pkg::*;

  localparam logic [ACC_W-1:0] BIAS = (ACC_W'(1) << FRAC_BITS) - ACC_W'(1);
  localparam logic [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  logic [ELEM_W-1:0] left_mem  [16];
  logic [ELEM_W-1:0] right_mem [16];

  logic adv;

  // stage 1: operand read
  logic              s1_v, s1_first, s1_lastk, s1_end;
  logic [ELEM_W-1:0] s1_a, s1_b;
  // stage 2: product
  logic              s2_v, s2_first, s2_lastk, s2_end;
  logic [PROD_W-1:0] s2_prod;
  // stage 3: accumulator
  logic              s3_v, s3_end;
  logic [ACC_W-1:0]  acc;
  // stage 4: scaled sum
  logic              s4_v, s4_end;
  logic [ACC_W-1:0]  s4_q;

  logic [ACC_W-1:0]  prod_ext, acc_next, biased;
  logic              q_fits;
  logic [ELEM_W-1:0] sat_val;

  // whole pipeline freezes while a result waits at the output
  assign adv      = !out_valid || out_ready;
  assign stat.adv = adv;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      left_mem[cmd.wr_addr]  <= left_element;
      right_mem[cmd.wr_addr] <= right_element;
    end
    if (adv) begin
      s1_a <= left_mem[cmd.left_addr];
      s1_b <= right_mem[cmd.right_addr];
    end
  end

  assign prod_ext = {{(ACC_W-PROD_W){s2_prod[PROD_W-1]}}, s2_prod};
  assign acc_next = s2_first ? prod_ext : acc + prod_ext;

  // truncate toward zero: negative sums get 2^F - 1 added before the shift
  assign biased  = acc + (acc[ACC_W-1] ? BIAS : '0);
  assign q_fits  = (s4_q[ACC_W-1:ELEM_W-1] == '0) || (s4_q[ACC_W-1:ELEM_W-1] == '1);
  assign sat_val = q_fits ? s4_q[ELEM_W-1:0] : (s4_q[ACC_W-1] ? SAT_MIN : SAT_MAX);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_first <= cmd.first_term;
      s1_lastk <= cmd.last_term;
      s1_end   <= cmd.last_elem;

      s2_prod  <= PROD_W'($signed(s1_a) * $signed(s1_b));
      s2_first <= s1_first;
      s2_lastk <= s1_lastk;
      s2_end   <= s1_end;

      if (s2_v) acc <= acc_next;
      s3_end <= s2_end;

      s4_q   <= ACC_W'($signed(biased) >>> FRAC_BITS);
      s4_end <= s3_end;

      product_element <= sat_val;
      last_out        <= s4_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      s4_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_v      <= cmd.issue;
      s2_v      <= s1_v;
      s3_v      <= s2_v && s2_lastk;
      s4_v      <= s3_v;
      out_valid <= s4_v;
    end
  end

endmodule

FILE: hdl/matrix4x4_multiply.sv
// 4x4 signed Q16.16 matrix multiply, one shared 32x32 MAC.
// Input is taken only in the load phase; once sixteen beats fill the element stores,
// s_axis_tready stays low while the terms are issued, four per result element on
// the single MAC, so loading and term issue never overlap.
// Reset (rst, synchronous, active high) clears the load counter, sequencer and
// pipeline valids; the element stores are not cleared.
`timescale 1ns / 1ps

module matrix4x4_multiply (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] left_element, [63:32] right_element
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] product_element
  output logic        m_axis_tlast
);
  import m4m_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  m4m_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  m4m_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .left_element    (s_axis_tdata[ELEM_W-1:0]),
    .right_element   (s_axis_tdata[2*ELEM_W-1:ELEM_W]),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .product_element (m_axis_tdata),
    .last_out        (m_axis_tlast)
  );

endmodule

FILE: verif/matrix4x4_multiply_test.sv
// Self-checking testbench for matrix4x4_multiply: streams 4x4 matrix pairs in,
// predicts each Q16.16 product element and checks every output beat in order.
// Depends on m4m_pkg (FRAC_BITS) and the matrix4x4_multiply RTL.
`timescale 1ns / 1ps

module matrix4x4_multiply_test;
  import m4m_pkg::*;

  localparam logic [31:0] ELEM_MIN  = 32'h8000_0000;
  localparam logic [31:0] ELEM_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] ELEM_ONE  = 32'h0001_0000;  // 1.0 in Q16.16
  localparam int          HOLD_LONG = 300;

  typedef enum {VAL_FULL, VAL_SMALL, VAL_EXTREME} value_class_t;

  typedef struct packed {
    logic [31:0] element;
    logic        last;
  } product_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;    // [31:0] left_element, [63:32] right_element
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [31:0] product_element
  logic        m_axis_tlast;

  // predictor state
  logic [31:0]   left_mat [16];
  logic [31:0]   right_mat[16];
  logic [3:0]    load_slot = '0;
  product_beat_t product_queue[$];

  int errors = 0;
  bit gaps_on = 1'b1;
  int sink_hold_cycles = 0;

  matrix4x4_multiply i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly zero, some short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Row . column at full width, scaled toward zero, saturated to 32 bits.
  function automatic logic [31:0] scaled_dot(int row, int col);
    logic signed [65:0] acc;
    logic signed [65:0] a_ext;
    logic signed [65:0] b_ext;
    logic [65:0]        mag;
    logic [65:0]        q;
    int                 k;
    acc = '0;
    for (k = 0; k < 4; k++) begin
      a_ext = $signed(left_mat[row * 4 + k]);
      b_ext = $signed(right_mat[k * 4 + col]);
      acc += a_ext * b_ext;
    end
    if (acc < 0) begin
      mag = -acc;
      q = mag >> FRAC_BITS;
      if (q > 66'h8000_0000) return ELEM_MIN;
      return -q[31:0];
    end
    mag = acc;
    q = mag >> FRAC_BITS;
    if (q > 66'h7FFF_FFFF) return ELEM_MAX;
    return q[31:0];
  endfunction

  function automatic void load_pair(logic [31:0] left_elem, logic [31:0] right_elem);
    int e;
    left_mat[load_slot]  = left_elem;
    right_mat[load_slot] = right_elem;
    if (load_slot == 4'd15) begin
      for (e = 0; e < 16; e++)
        product_queue.push_back('{element: scaled_dot(e / 4, e % 4), last: (e == 15)});
    end
    load_slot = load_slot + 4'd1;
  endfunction

  function automatic logic [31:0] rand_element();
    value_class_t cls;
    int           roll;
    roll = $urandom_range(0, 9);
    cls = (roll < 4) ? VAL_FULL : (roll < 8) ? VAL_SMALL : VAL_EXTREME;
    case (cls)
      VAL_FULL:  return $urandom;
      VAL_SMALL: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
      default: begin
        case ($urandom_range(0, 5))
          0: return ELEM_MIN;
          1: return ELEM_MAX;
          2: return 32'h0;
          3: return 32'hFFFF_FFFF;
          4: return 32'h1;
          default: return ELEM_ONE;
        endcase
      end
    endcase
  endfunction

  // Called in the rising-edge time step; leaves tvalid high after the beat.
  task automatic send_pair(logic [31:0] left_elem, logic [31:0] right_elem);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {right_elem, left_elem};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    load_pair(left_elem, right_elem);
  endtask

  task automatic send_random_group();
    int i;
    for (i = 0; i < 16; i++) send_pair(rand_element(), rand_element());
  endtask

  // Drop tvalid and wait for every outstanding product beat.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (product_queue.size() != 0);
  endtask

  // Saturation both ways, rounding toward zero on negatives, zero sums.
  task automatic test_directed_group();
    logic [31:0] a[16];
    logic [31:0] b[16];
    int          k;
    a = '{ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN,
          32'hFFFF_FFFF, ELEM_MAX, 32'h0, 32'h1,
          ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX,
          ELEM_ONE, -ELEM_ONE, 32'h0000_8000, -32'sd3};
    for (k = 0; k < 4; k++) begin
      b[k * 4 + 0] = ELEM_MIN;
      b[k * 4 + 1] = ELEM_MAX;
      b[k * 4 + 2] = (k == 0) ? 32'h1 : (k == 3) ? 32'hFFFF_FFFF : 32'h0;
      b[k * 4 + 3] = (k == 1) ? ELEM_ONE : 32'h0;
    end
    for (k = 0; k < 16; k++) send_pair(a[k], b[k]);
    drain();
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    repeat (3) send_random_group();
    drain();
    gaps_on = 1'b1;
  endtask

  // Sink holds off while two groups are offered, so the input stalls.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    sink_hold_cycles = HOLD_LONG;
    repeat (2) send_random_group();
    drain();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_groups(int groups);
    int g;
    for (g = 0; g < groups; g++) begin
      send_random_group();
      if ($urandom_range(0, 7) == 0) drain();
    end
    drain();
  endtask

  // Sink: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (sink_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (sink_hold_cycles) @(posedge clk);
        sink_hold_cycles = 0;
        m_axis_tready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
          @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Output checker: compare each accepted beat with the oldest prediction.
  always @(posedge clk) begin
    product_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (product_queue.size() == 0) begin
        $error("unexpected product beat: product_element %h last_out %b",
               m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        want = product_queue.pop_front();
        if (m_axis_tdata !== want.element) begin
          $error("product_element: expected %h, got %h", want.element, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_out: expected %b, got %b", want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("matrix4x4_multiply test failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_group();
    test_back_to_back();
    test_backpressure();
    test_random_groups(19);
    repeat (40) @(posedge clk);
    if (errors == 0 && product_queue.size() == 0) begin
      $display("matrix4x4_multiply test passed");
    end else begin
      $display("matrix4x4_multiply test failed");
    end
    $finish;
  end

endmodule
